>>> rtl/mff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_pkg
// Shared types and constants of the multichannel frame FIFO.
// ----------------------------------------------------------------------------
package mff_pkg;

	// fixed field widths of the ports
	localparam int NUM_LANES = 8;
	localparam int LANE_W    = 32;
	localparam int CAP_W     = 11;
	localparam int CHN_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IDX_MAX_W = 16;

	// largest capacity that the capacity register can encode
	localparam int CAP_FIELD_MAX = 2047;

	// operation codes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY = 2'd0,
		REG_CHANNELS = 2'd1
	} reg_t;

	// memory access request from the pointer logic
	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [IDX_MAX_W-1:0] waddr;
		logic [IDX_MAX_W-1:0] raddr;
	} mem_req_t;

	// per-request result info carried to the output stage
	typedef struct packed {
		logic             accepted;
		logic             rd_ok;
		logic [CHN_W-1:0] chans;
		logic [CAP_W-1:0] stored;
		logic [CAP_W-1:0] free;
	} res_info_t;

endpackage

>>> rtl/mff_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_store
// Frame memory: one frame per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
module mff_store import mff_pkg::*; #(
	parameter int DEPTH_FRAMES = 1024,
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 32
) (
	input  logic                                clk,
	input  mem_req_t                            req,
	input  logic [MAX_CHANNELS*SAMPLE_BITS-1:0] wr_frame,
	output logic [MAX_CHANNELS*SAMPLE_BITS-1:0] rd_frame
);

	localparam int AW = $clog2(DEPTH_FRAMES);

	logic [MAX_CHANNELS*SAMPLE_BITS-1:0] mem_q [DEPTH_FRAMES];
	logic [MAX_CHANNELS*SAMPLE_BITS-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr[AW-1:0]] <= wr_frame;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_q <= mem_q[req.raddr[AW-1:0]];
		end
	end

	assign rd_frame = rd_q;

endmodule

>>> rtl/mff_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mff_ctrl
// Configuration registers, head/tail pointers and fill count; decides each
// request and issues the frame memory accesses.
// ----------------------------------------------------------------------------
module mff_ctrl import mff_pkg::*; #(
	parameter int DEPTH_FRAMES = 1024,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           op,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	output mem_req_t             req,
	output res_info_t            info
);

	localparam int AW      = $clog2(DEPTH_FRAMES);
	localparam int CAP_MAX = (DEPTH_FRAMES > CAP_FIELD_MAX) ? CAP_FIELD_MAX : DEPTH_FRAMES;
	localparam int CAP_RST = (CAP_MAX < 1024) ? CAP_MAX : 1024;
	localparam int CHN_RST = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

	logic [CAP_W-1:0] cap_q;
	logic [CHN_W-1:0] chans_q;
	logic [AW-1:0]    wr_idx_q;
	logic [AW-1:0]    rd_idx_q;
	logic [CAP_W-1:0] fill_q;

	logic             wr_ok;
	logic             rd_ok;
	logic             clr;
	logic             acc;
	logic [CAP_W-1:0] fill_nxt;
	logic [CAP_W-1:0] cap_wr;
	logic [CHN_W-1:0] chans_wr;

	// pointer advance with wrap at the configured capacity
	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
		input logic [CAP_W-1:0] cap);
		logic [31:0] n;
		n = 32'(i) + 32'd1;
		return (n >= 32'(cap)) ? '0 : AW'(n);
	endfunction

	// saturate configuration values
	always_comb begin
		cap_wr = cfg_data;
		if (cfg_data == '0) begin
			cap_wr = CAP_W'(1);
		end else if (32'(cfg_data) > CAP_MAX) begin
			cap_wr = CAP_W'(CAP_MAX);
		end
		chans_wr = cfg_data[CHN_W-1:0];
		if (cfg_data[CHN_W-1:0] == '0) begin
			chans_wr = CHN_W'(1);
		end else if (32'(cfg_data[CHN_W-1:0]) > MAX_CHANNELS) begin
			chans_wr = CHN_W'(MAX_CHANNELS);
		end
	end

	// request decision
	always_comb begin
		wr_ok    = 1'b0;
		rd_ok    = 1'b0;
		clr      = 1'b0;
		acc      = 1'b0;
		fill_nxt = fill_q;
		unique case (op_t'(op))
			OP_WRITE: begin
				if (fill_q != cap_q) begin
					wr_ok    = 1'b1;
					acc      = 1'b1;
					fill_nxt = fill_q + CAP_W'(1);
				end
			end
			OP_READ: begin
				if (fill_q != '0) begin
					rd_ok    = 1'b1;
					acc      = 1'b1;
					fill_nxt = fill_q - CAP_W'(1);
				end
			end
			OP_CLEAR: begin
				clr      = 1'b1;
				acc      = 1'b1;
				fill_nxt = '0;
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	// memory requests and result info
	always_comb begin
		req.we      = accept && wr_ok;
		req.re      = accept && rd_ok;
		req.waddr   = IDX_MAX_W'(wr_idx_q);
		req.raddr   = IDX_MAX_W'(rd_idx_q);
		info.accepted = acc;
		info.rd_ok    = rd_ok;
		info.chans    = chans_q;
		info.stored   = fill_nxt;
		info.free     = cap_q - fill_nxt;
	end

	// configuration and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_W'(CAP_RST);
			chans_q  <= CHN_W'(CHN_RST);
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_index))
				REG_CAPACITY: begin
					cap_q    <= cap_wr;
					wr_idx_q <= '0;
					rd_idx_q <= '0;
					fill_q   <= '0;
				end
				REG_CHANNELS: begin
					chans_q  <= chans_wr;
					wr_idx_q <= '0;
					rd_idx_q <= '0;
					fill_q   <= '0;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end else if (accept) begin
			fill_q <= fill_nxt;
			if (clr) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
			end
			if (wr_ok) begin
				wr_idx_q <= next_idx(wr_idx_q, cap_q);
			end
			if (rd_ok) begin
				rd_idx_q <= next_idx(rd_idx_q, cap_q);
			end
		end
	end

	// fill count never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill count above capacity");

	// both pointers stay inside the active ring
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(wr_idx_q) < 32'(cap_q)) && (32'(rd_idx_q) < 32'(cap_q)))
		else $error("pointer outside capacity");

	// an accepted write grows the fill count by one
	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wr_ok && !cfg_we) |=> fill_q == $past(fill_q) + CAP_W'(1))
		else $error("write did not advance fill count");

endmodule

>>> rtl/multichannel_frame_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_frame_fifo_top
// Circular FIFO of multichannel audio frames with write, read and clear
// requests and configurable capacity and channel count.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes stage 1, then the output register.
// Throughput: one request per cycle while in_stall is low; the frame memory
// read is registered, which sets the extra stage ahead of the output register.
// Reset: arst_n clears pointers, fill count, configuration and valid flags at
// once; frame memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_frame_fifo_top import mff_pkg::*; #(
	parameter int DEPTH_FRAMES = 1024,
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [LANE_W-1:0]    in_ch0,
	input  logic [LANE_W-1:0]    in_ch1,
	input  logic [LANE_W-1:0]    in_ch2,
	input  logic [LANE_W-1:0]    in_ch3,
	input  logic [LANE_W-1:0]    in_ch4,
	input  logic [LANE_W-1:0]    in_ch5,
	input  logic [LANE_W-1:0]    in_ch6,
	input  logic [LANE_W-1:0]    in_ch7,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 accepted,
	output logic [LANE_W-1:0]    out_ch0,
	output logic [LANE_W-1:0]    out_ch1,
	output logic [LANE_W-1:0]    out_ch2,
	output logic [LANE_W-1:0]    out_ch3,
	output logic [LANE_W-1:0]    out_ch4,
	output logic [LANE_W-1:0]    out_ch5,
	output logic [LANE_W-1:0]    out_ch6,
	output logic [LANE_W-1:0]    out_ch7,
	output logic [CAP_W-1:0]     frames_stored,
	output logic [CAP_W-1:0]     frames_free,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data
);

	logic                                accept;
	logic                                adv;
	mem_req_t                            req;
	res_info_t                           info;
	res_info_t                           info_s1;
	logic                                valid_s1;
	logic [MAX_CHANNELS*SAMPLE_BITS-1:0] wr_frame;
	logic [MAX_CHANNELS*SAMPLE_BITS-1:0] rd_frame;
	logic [LANE_W-1:0]                   in_all [NUM_LANES];
	logic [LANE_W-1:0]                   lane_d [NUM_LANES];
	logic [LANE_W-1:0]                   lane_q [NUM_LANES];
	logic                                out_valid_q;
	logic                                acc_q;
	logic [CAP_W-1:0]                    stored_q;
	logic [CAP_W-1:0]                    free_q;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);

	// pack the stored lanes of the incoming frame
	assign in_all[0] = in_ch0;
	assign in_all[1] = in_ch1;
	assign in_all[2] = in_ch2;
	assign in_all[3] = in_ch3;
	assign in_all[4] = in_ch4;
	assign in_all[5] = in_ch5;
	assign in_all[6] = in_ch6;
	assign in_all[7] = in_ch7;

	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_pack
		assign wr_frame[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(in_all[c]);
	end

	mff_ctrl #(
		.DEPTH_FRAMES(DEPTH_FRAMES),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.info     (info)
	);

	mff_store #(
		.DEPTH_FRAMES(DEPTH_FRAMES),
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.req     (req),
		.wr_frame(wr_frame),
		.rd_frame(rd_frame)
	);

	// stage 1: wait for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// lane select: only read lanes below the channel count
	for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
		if (c < MAX_CHANNELS) begin : g_used
			assign lane_d[c] = (info_s1.rd_ok && (CHN_W'(c) < info_s1.chans))
				? LANE_W'(rd_frame[c*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
		end else begin : g_unused
			assign lane_d[c] = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q    <= info_s1.accepted;
			stored_q <= info_s1.stored;
			free_q   <= info_s1.free;
			for (int c = 0; c < NUM_LANES; c++) begin
				lane_q[c] <= lane_d[c];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = acc_q;
	assign frames_stored = stored_q;
	assign frames_free   = free_q;
	assign out_ch0       = lane_q[0];
	assign out_ch1       = lane_q[1];
	assign out_ch2       = lane_q[2];
	assign out_ch3       = lane_q[3];
	assign out_ch4       = lane_q[4];
	assign out_ch5       = lane_q[5];
	assign out_ch6       = lane_q[6];
	assign out_ch7       = lane_q[7];

	// every accepted request occupies stage 1 next cycle
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before stage 1");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room in the pipeline");

	// a refused result carries no samples in its first and last lanes
	a_zero_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !acc_q) |-> (lane_q[0] == '0 && lane_q[NUM_LANES-1] == '0))
		else $error("sample data on a refused request");

endmodule

>>> verif/tb_multichannel_frame_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_frame_fifo_top
// Self-checking bench for the multichannel frame FIFO. A short directed table
// covers empty reads, full writes, clears, the unused opcode and saturating
// register values. Random phases follow under many capacity and channel
// settings, including a fill to the full 1024-frame depth. Each result is
// checked field by field against a cycle-free predictor of the FIFO, with
// random idle gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_multichannel_frame_fifo_top import mff_pkg::*;;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 9;
	localparam int FIFO_DEPTH   = 1024;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_PRINT    = 100;

	// opcode and register indexes that the package leaves unnamed
	localparam logic [1:0]           OP_NONE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

	typedef struct packed {
		logic             acc;
		lanes_t           lanes;
		logic [CAP_W-1:0] stored;
		logic [CAP_W-1:0] free;
	} frame_res_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CAP_W-1:0]     data;
		logic [1:0]           opc;
		lanes_t               smp;
		bit                   typed;
		frame_res_t           exp;
	} dir_row_t;

	localparam lanes_t FRAME_ZERO = '0;
	localparam lanes_t FRAME_ONES = '1;
	localparam lanes_t FRAME_LO2  = {{(6*LANE_W){1'b0}}, {(2*LANE_W){1'b1}}};
	localparam lanes_t FRAME_LO1  = {{(7*LANE_W){1'b0}}, {LANE_W{1'b1}}};
	localparam lanes_t FRAME_ALT  = {4{32'h5A5A_A5A5, 32'hA5A5_5A5A}};

	logic clk = 1'b0;
	logic arst_n;

	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           op;
	lanes_t               drv_smp;
	logic                 out_valid;
	logic                 out_stall;
	logic                 accepted;
	logic [LANE_W-1:0]    out_ch0, out_ch1, out_ch2, out_ch3;
	logic [LANE_W-1:0]    out_ch4, out_ch5, out_ch6, out_ch7;
	logic [CAP_W-1:0]     frames_stored;
	logic [CAP_W-1:0]     frames_free;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0]     cfg_data;

	// typed expectation that travels with the current request
	bit         row_typed;
	frame_res_t row_exp;

	// predictor state
	lanes_t      frame_mem [FIFO_DEPTH];
	int unsigned wr_ptr   = 0;
	int unsigned rd_ptr   = 0;
	int unsigned fill_cnt = 0;
	int unsigned cap_eff  = FIFO_DEPTH;
	int unsigned chan_eff = 2;

	frame_res_t  expected_q [$];
	int unsigned err_count = 0;
	int unsigned res_cnt   = 0;
	int unsigned cycle_cnt = 0;
	bit          in_quiet  = 1'b0;
	bit          out_quiet = 1'b0;
	int unsigned ostall_left = 0;
	int unsigned ostall_len;

	always #(CLK_PERIOD/2) clk = ~clk;

	multichannel_frame_fifo_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.in_ch0        (drv_smp[0]),
		.in_ch1        (drv_smp[1]),
		.in_ch2        (drv_smp[2]),
		.in_ch3        (drv_smp[3]),
		.in_ch4        (drv_smp[4]),
		.in_ch5        (drv_smp[5]),
		.in_ch6        (drv_smp[6]),
		.in_ch7        (drv_smp[7]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.out_ch0       (out_ch0),
		.out_ch1       (out_ch1),
		.out_ch2       (out_ch2),
		.out_ch3       (out_ch3),
		.out_ch4       (out_ch4),
		.out_ch5       (out_ch5),
		.out_ch6       (out_ch6),
		.out_ch7       (out_ch7),
		.frames_stored (frames_stored),
		.frames_free   (frames_free),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic lanes_t rand_frame();
		lanes_t      f;
		int unsigned r;
		for (int l = 0; l < NUM_LANES; l++) begin
			r = $urandom_range(0, 15);
			if (r == 0)
				f[l] = '0;
			else if (r == 1)
				f[l] = '1;
			else
				f[l] = $urandom;
		end
		return f;
	endfunction

	function automatic frame_res_t fres(bit a, lanes_t l, int unsigned st, int unsigned fr);
		frame_res_t r;
		r.acc    = a;
		r.lanes  = l;
		r.stored = CAP_W'(st);
		r.free   = CAP_W'(fr);
		return r;
	endfunction

	function automatic dir_row_t dreq(logic [1:0] opc, lanes_t smp, bit typed,
		frame_res_t exp);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.idx    = '0;
		row.data   = '0;
		row.opc    = opc;
		row.smp    = smp;
		row.typed  = typed;
		row.exp    = exp;
		return row;
	endfunction

	function automatic dir_row_t dcfg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
		dir_row_t row;
		row        = dreq(OP_NONE, FRAME_ZERO, 1'b0, '0);
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		return row;
	endfunction

	// register write: saturate the value and empty the fifo
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
		int unsigned v;
		if (idx == REG_CAPACITY) begin
			v = 32'(data);
			cap_eff = (v == 0) ? 1 : ((v > FIFO_DEPTH) ? FIFO_DEPTH : v);
		end else if (idx == REG_CHANNELS) begin
			v = 32'(data[CHN_W-1:0]);
			chan_eff = (v == 0) ? 1 : ((v > NUM_LANES) ? NUM_LANES : v);
		end else begin
			return;
		end
		wr_ptr   = 0;
		rd_ptr   = 0;
		fill_cnt = 0;
	endfunction

	// one fifo operation on the predictor state
	function automatic frame_res_t predict_frame(logic [1:0] opc, lanes_t smp);
		frame_res_t r;
		r = '0;
		case (opc)
			OP_WRITE: begin
				if (fill_cnt < cap_eff) begin
					frame_mem[wr_ptr] = smp;
					wr_ptr = (wr_ptr + 1 >= cap_eff) ? 0 : wr_ptr + 1;
					fill_cnt++;
					r.acc = 1'b1;
				end
			end
			OP_READ: begin
				if (fill_cnt > 0) begin
					for (int l = 0; l < NUM_LANES; l++)
						if (l < chan_eff)
							r.lanes[l] = frame_mem[rd_ptr][l];
					rd_ptr = (rd_ptr + 1 >= cap_eff) ? 0 : rd_ptr + 1;
					fill_cnt--;
					r.acc = 1'b1;
				end
			end
			OP_CLEAR: begin
				wr_ptr   = 0;
				rd_ptr   = 0;
				fill_cnt = 0;
				r.acc    = 1'b1;
			end
			default: ;
		endcase
		r.stored = CAP_W'(fill_cnt);
		r.free   = CAP_W'(cap_eff - fill_cnt);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	// predict on each accepted request, check each accepted result
	always @(posedge clk) begin : scoreboard
		frame_res_t want;
		frame_res_t got;
		if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
			apply_reg(cfg_index, cfg_data);
		if (in_valid === 1'b1 && in_stall === 1'b0) begin
			want = predict_frame(op, drv_smp);
			if (row_typed)
				want = row_exp;
			expected_q.push_back(want);
		end
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got.acc    = accepted;
			got.lanes  = {out_ch7, out_ch6, out_ch5, out_ch4,
				out_ch3, out_ch2, out_ch1, out_ch0};
			got.stored = frames_stored;
			got.free   = frames_free;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request pending",
					res_cnt));
			end else begin
				want = expected_q.pop_front();
				if (got.acc !== want.acc)
					report_mismatch($sformatf("result %0d accepted %b, expected %b",
						res_cnt, got.acc, want.acc));
				for (int l = 0; l < NUM_LANES; l++)
					if (got.lanes[l] !== want.lanes[l])
						report_mismatch($sformatf("result %0d out_ch%0d %h, expected %h",
							res_cnt, l, got.lanes[l], want.lanes[l]));
				if (got.stored !== want.stored)
					report_mismatch($sformatf("result %0d frames_stored %0d, expected %0d",
						res_cnt, got.stored, want.stored));
				if (got.free !== want.free)
					report_mismatch($sformatf("result %0d frames_free %0d, expected %0d",
						res_cnt, got.free, want.free));
			end
			res_cnt++;
		end
	end

	// result side stalls, with quiet stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			out_quiet <= !out_quiet;
		if (ostall_left > 0) begin
			out_stall   <= 1'b1;
			ostall_left <= ostall_left - 1;
		end else begin
			ostall_len = out_quiet ? 0 : idle_len();
			out_stall   <= (ostall_len > 0);
			ostall_left <= (ostall_len > 0) ? ostall_len - 1 : 0;
		end
	end

	// run limit
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// one request, after a random gap
	task automatic send_req(input logic [1:0] opc, input lanes_t smp, input bit typed,
		input frame_res_t exp);
		int unsigned n;
		if ($urandom_range(0, 49) == 0)
			in_quiet = !in_quiet;
		n = in_quiet ? 0 : idle_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= opc;
		drv_smp   <= smp;
		row_typed <= typed;
		row_exp   <= exp;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// register write; hold keeps valid up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] data,
		input bit hold);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (!hold)
			cfg_valid <= 1'b0;
	endtask

	// stop requests and wait for every pending result
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_mix(input int unsigned count, input int unsigned write_pct,
		input bit with_clear);
		logic [1:0]  opc;
		int unsigned r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (with_clear && r < 3)
				opc = OP_CLEAR;
			else if (with_clear && r < 5)
				opc = OP_NONE;
			else if ($urandom_range(0, 99) < write_pct)
				opc = OP_WRITE;
			else
				opc = OP_READ;
			send_req(opc, rand_frame(), 1'b0, '0);
		end
	endtask

	// new setting, then a filling half and a draining half
	task automatic run_phase(input int unsigned cap, input int unsigned chans,
		input int unsigned count);
		logic [CAP_W-1:0] chan_word;
		chan_word = CAP_W'(($urandom_range(0, 127) << CHN_W) | chans);
		wait_idle();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_CAPACITY, CAP_W'(cap), 1'b1);
			write_reg(REG_CHANNELS, chan_word, 1'b0);
		end else begin
			write_reg(REG_CHANNELS, chan_word, 1'b1);
			write_reg(REG_CAPACITY, CAP_W'(cap), 1'b0);
		end
		run_mix(count / 2, 70, 1'b1);
		run_mix(count - count / 2, 30, 1'b1);
	endtask

	initial begin
		dir_row_t dir_rows [$];

		// inputs known from time zero
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		op        <= OP_WRITE;
		drv_smp   <= '0;
		row_typed <= 1'b0;
		row_exp   <= '0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CAPACITY;
		cfg_data  <= '0;

		// directed table, reset setting first: capacity 1024, two channels
		dir_rows.push_back(dreq(OP_READ,  FRAME_ONES, 1'b1, fres(1'b0, FRAME_ZERO, 0, 1024)));
		dir_rows.push_back(dreq(OP_NONE,  FRAME_ONES, 1'b1, fres(1'b0, FRAME_ZERO, 0, 1024)));
		dir_rows.push_back(dreq(OP_CLEAR, FRAME_ONES, 1'b1, fres(1'b1, FRAME_ZERO, 0, 1024)));
		dir_rows.push_back(dreq(OP_WRITE, FRAME_ONES, 1'b1, fres(1'b1, FRAME_ZERO, 1, 1023)));
		dir_rows.push_back(dreq(OP_WRITE, FRAME_ZERO, 1'b1, fres(1'b1, FRAME_ZERO, 2, 1022)));
		dir_rows.push_back(dreq(OP_WRITE, FRAME_ALT,  1'b0, '0));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b1, fres(1'b1, FRAME_LO2, 2, 1022)));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ONES, 1'b1, fres(1'b1, FRAME_ZERO, 1, 1023)));
		dir_rows.push_back(dreq(OP_NONE,  FRAME_ONES, 1'b0, '0));
		dir_rows.push_back(dreq(OP_CLEAR, FRAME_ZERO, 1'b1, fres(1'b1, FRAME_ZERO, 0, 1024)));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b1, fres(1'b0, FRAME_ZERO, 0, 1024)));
		// single-frame buffer with all lanes: full write and empty read
		dir_rows.push_back(dcfg(REG_CAPACITY, 11'd1));
		dir_rows.push_back(dcfg(REG_CHANNELS, 11'd8));
		dir_rows.push_back(dreq(OP_WRITE, rand_frame(), 1'b0, '0));
		dir_rows.push_back(dreq(OP_WRITE, FRAME_ONES, 1'b1, fres(1'b0, FRAME_ZERO, 1, 0)));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b0, '0));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b1, fres(1'b0, FRAME_ZERO, 0, 1)));
		dir_rows.push_back(dreq(OP_WRITE, FRAME_ONES, 1'b1, fres(1'b1, FRAME_ZERO, 1, 0)));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b1, fres(1'b1, FRAME_ONES, 0, 1)));
		// saturating values: capacity above depth, channel count zero
		dir_rows.push_back(dcfg(REG_CAPACITY, 11'h7FF));
		dir_rows.push_back(dcfg(REG_CHANNELS, 11'd0));
		dir_rows.push_back(dreq(OP_WRITE, FRAME_ONES, 1'b1, fres(1'b1, FRAME_ZERO, 1, 1023)));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b1, fres(1'b1, FRAME_LO1, 0, 1024)));
		// capacity zero, channel count above the lane count
		dir_rows.push_back(dcfg(REG_CAPACITY, 11'd0));
		dir_rows.push_back(dcfg(REG_CHANNELS, 11'h7FF));
		dir_rows.push_back(dreq(OP_WRITE, rand_frame(), 1'b0, '0));
		dir_rows.push_back(dreq(OP_READ,  FRAME_ZERO, 1'b0, '0));

		// reset once
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				wait_idle();
				write_reg(dir_rows[k].idx, dir_rows[k].data, 1'b0);
			end else begin
				send_req(dir_rows[k].opc, dir_rows[k].smp, dir_rows[k].typed,
					dir_rows[k].exp);
			end
		end

		// small buffers, wrapping often
		run_phase(1, 8, 60);
		run_phase(0, 0, 40);
		run_phase(2, 3, 60);
		run_phase(5, 15, 60);
		run_phase(7, 4, 70);

		// unused register index must keep the stored frames
		run_phase(16, 5, 40);
		wait_idle();
		write_reg(REG_SPARE_A, CAP_W'($urandom), 1'b0);
		run_mix(40, 45, 1'b1);

		// full depth: fill past full, then mixed traffic across the wrap
		wait_idle();
		write_reg(REG_CAPACITY, 11'h7FF, 1'b1);
		write_reg(REG_CHANNELS, CAP_W'(8), 1'b0);
		run_mix(1030, 100, 1'b0);
		run_mix(200, 40, 1'b1);

		// random settings
		run_phase($urandom_range(0, 40), $urandom_range(0, 15), 80);
		run_phase($urandom_range(0, 40), $urandom_range(0, 15), 80);
		run_phase(1024, 7, 60);
		wait_idle();
		write_reg(REG_SPARE_B, CAP_W'($urandom), 1'b0);
		run_mix(30, 50, 1'b1);

		// drain and settle
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
